FILE: rtl/core/bwt_pkg.sv
package bwt_pkg;

	localparam int NSLOT = 16;
	localparam int SLOT_BITS = $clog2(NSLOT);
	localparam int CNT_BITS = $clog2(NSLOT + 1);
	localparam int ADDR_W = 24;
	localparam int QDEPTH = 2;

	localparam logic [3:0] F_ADD = 4'd0;
	localparam logic [3:0] F_REMOVE = 4'd1;
	localparam logic [3:0] F_ENABLE = 4'd2;
	localparam logic [3:0] F_CLR_ALL = 4'd3;
	localparam logic [3:0] F_CLR_CPU = 4'd4;
	localparam logic [3:0] F_RST_HITS = 4'd5;
	localparam logic [3:0] F_EXEC = 4'd6;
	localparam logic [3:0] F_ACCESS = 4'd7;
	localparam logic [3:0] F_LIST_ALL = 4'd8;
	localparam logic [3:0] F_LIST_CPU = 4'd9;
	localparam logic [3:0] F_LAST_HIT = 4'd10;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] K_EXEC = 2'd0;
	localparam logic [1:0] K_READ = 2'd1;
	localparam logic [1:0] K_WRITE = 2'd2;
	localparam logic [1:0] K_ANY = 2'd3;

	typedef struct packed {
		logic [3:0]        func;
		logic [ADDR_W-1:0] address;
		logic [1:0]        access_kind;
		logic              cpu;
		logic              wr_access;
		logic [15:0]       bp_id;
		logic              enable;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              hit;
		logic              entry_valid;
		logic [15:0]       entry_id;
		logic [ADDR_W-1:0] entry_address;
		logic [1:0]        entry_kind;
		logic              entry_cpu;
		logic              entry_enabled;
		logic [31:0]       entry_hits;
		logic              last;
	} rsp_t;

endpackage

FILE: rtl/core/bwt_front.sv
// front: accepts requests, drops unused codes, holds a short fifo
module bwt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bwt_pkg::req_t req,
	output logic          full,
	output logic          pending,
	input  logic          pop,
	output bwt_pkg::req_t head
);

	localparam int PW = $clog2(bwt_pkg::QDEPTH);

	bwt_pkg::req_t mem_q [bwt_pkg::QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push;

	assign full = (cnt_q == (PW+1)'(bwt_pkg::QDEPTH));
	assign pending = (cnt_q != '0);
	// codes above last hit produce nothing
	assign push = start && !full && (req.func <= bwt_pkg::F_LAST_HIT);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("fifo overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pending) else $error("fifo underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count");

endmodule

FILE: rtl/core/bwt_back.sv
// back: the table and its sequencer
module bwt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pending,
	input  bwt_pkg::req_t head,
	output logic          pop,
	output logic          busy,
	output logic          done,
	output bwt_pkg::rsp_t rsp
);

	localparam int N = bwt_pkg::NSLOT;
	localparam int SB = bwt_pkg::SLOT_BITS;
	localparam int CB = bwt_pkg::CNT_BITS;
	localparam int AW = bwt_pkg::ADDR_W;

	typedef enum logic [1:0] {IDLE, LIST} state_t;

	logic [N-1:0]  valid_q;
	logic [15:0]   id_q [N];
	logic [AW-1:0] addr_q [N];
	logic [1:0]    kind_q [N];
	logic          cpu_q [N];
	logic          en_q [N];
	logic [31:0]   hits_q [N];
	logic [15:0]   next_id_q;
	logic [15:0]   lh_id_q;
	logic          lh_valid_q;

	state_t        state_q;
	bwt_pkg::req_t cur_q;
	// lowest id still to be listed
	logic [16:0]   prev_q;
	logic [CB-1:0] n_q;

	// per-slot match vectors
	logic [N-1:0] id_m, nid_m, lh_m, chk_m, lst_m, free_m;
	always_comb begin
		for (int i = 0; i < N; i++) begin
			id_m[i] = valid_q[i] && id_q[i] == head.bp_id;
			nid_m[i] = valid_q[i] && id_q[i] == next_id_q;
			lh_m[i] = valid_q[i] && id_q[i] == lh_id_q;
			free_m[i] = !valid_q[i];
			chk_m[i] = valid_q[i] && en_q[i] && addr_q[i] == head.address &&
				((head.func == bwt_pkg::F_EXEC) ?
					(kind_q[i] == bwt_pkg::K_EXEC && cpu_q[i] == head.cpu) :
					(kind_q[i] == bwt_pkg::K_ANY ||
					 (kind_q[i] == bwt_pkg::K_READ && !head.wr_access) ||
					 (kind_q[i] == bwt_pkg::K_WRITE && head.wr_access)));
			lst_m[i] = valid_q[i] && {1'b0, id_q[i]} >= prev_q &&
				(cur_q.func == bwt_pkg::F_LIST_ALL || cpu_q[i] == cur_q.cpu);
		end
	end

	// smallest-id pick over a mask as a balanced tree, and first-set search
	function automatic logic [SB:0] pick_min(input logic [N-1:0] m,
		input logic [15:0] ids [N]);
		logic [SB:0] nd [2*N-1];
		logic [15:0] kv [2*N-1];
		for (int i = 0; i < N; i++) begin
			nd[N-1+i] = m[i] ? {1'b0, SB'(i)} : '1;
			kv[N-1+i] = ids[i];
		end
		for (int k = N-2; k >= 0; k--) begin
			if (!nd[2*k+2][SB] && (nd[2*k+1][SB] || kv[2*k+2] < kv[2*k+1])) begin
				nd[k] = nd[2*k+2];
				kv[k] = kv[2*k+2];
			end else begin
				nd[k] = nd[2*k+1];
				kv[k] = kv[2*k+1];
			end
		end
		return nd[0];
	endfunction

	function automatic logic [SB:0] first(input logic [N-1:0] m);
		logic [SB:0] b;
		b = '1;
		for (int i = N-1; i >= 0; i--)
			if (m[i]) b = {1'b0, SB'(i)};
		return b;
	endfunction

	logic [SB:0] id_s, nid_s, lh_s, chk_s, lst_s, free_s, add_s;
	assign id_s = first(id_m);
	assign nid_s = first(nid_m);
	assign lh_s = first(lh_m);
	assign free_s = first(free_m);
	assign chk_s = pick_min(chk_m, id_q);
	assign lst_s = pick_min(lst_m, id_q);
	assign add_s = nid_s[SB] ? free_s : nid_s;

	assign busy = (state_q != IDLE);
	assign pop = pending && state_q == IDLE;

	function automatic bwt_pkg::rsp_t entry(
		input logic [15:0] id, input logic [AW-1:0] a, input logic [1:0] k,
		input logic c, input logic e, input logic [31:0] h);
		bwt_pkg::rsp_t r;
		r = '0;
		r.entry_valid = 1'b1;
		r.entry_id = id;
		r.entry_address = a;
		r.entry_kind = k;
		r.entry_cpu = c;
		r.entry_enabled = e;
		r.entry_hits = h;
		r.last = 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		bwt_pkg::rsp_t r;
		logic [SB-1:0] s;
		logic [31:0]   h;
		logic          d;
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= 16'd1;
			lh_id_q <= '0;
			lh_valid_q <= 1'b0;
			state_q <= IDLE;
			done <= 1'b0;
			prev_q <= '0;
			n_q <= '0;
		end else begin
			d = 1'b0;
			r = '0;
			r.last = 1'b1;
			case (state_q)
				IDLE: begin
					if (pop) begin
						d = 1'b1;
						cur_q <= head;
						case (head.func)
							bwt_pkg::F_ADD: begin
								if (add_s[SB]) r.status = bwt_pkg::ST_FULL;
								else begin
									s = add_s[SB-1:0];
									valid_q[s] <= 1'b1;
									id_q[s] <= next_id_q;
									addr_q[s] <= head.address;
									kind_q[s] <= head.access_kind;
									cpu_q[s] <= head.cpu;
									en_q[s] <= 1'b1;
									hits_q[s] <= '0;
									next_id_q <= next_id_q + 16'd1;
									r = entry(next_id_q, head.address,
										head.access_kind, head.cpu, 1'b1, '0);
								end
							end
							bwt_pkg::F_REMOVE: begin
								if (id_s[SB]) r.status = bwt_pkg::ST_NOT_FOUND;
								else begin
									valid_q[id_s[SB-1:0]] <= 1'b0;
									if (lh_valid_q && head.bp_id == lh_id_q)
										lh_valid_q <= 1'b0;
								end
							end
							bwt_pkg::F_ENABLE: begin
								if (id_s[SB]) r.status = bwt_pkg::ST_NOT_FOUND;
								else begin
									s = id_s[SB-1:0];
									en_q[s] <= head.enable;
									r = entry(id_q[s], addr_q[s], kind_q[s],
										cpu_q[s], head.enable, hits_q[s]);
								end
							end
							bwt_pkg::F_CLR_ALL, bwt_pkg::F_CLR_CPU: begin
								for (int i = 0; i < N; i++)
									if (valid_q[i] && (head.func == bwt_pkg::F_CLR_ALL ||
										cpu_q[i] == head.cpu)) begin
										valid_q[i] <= 1'b0;
										if (lh_valid_q && id_q[i] == lh_id_q)
											lh_valid_q <= 1'b0;
									end
							end
							bwt_pkg::F_RST_HITS: begin
								for (int i = 0; i < N; i++) hits_q[i] <= '0;
							end
							bwt_pkg::F_EXEC, bwt_pkg::F_ACCESS: begin
								if (!chk_s[SB]) begin
									s = chk_s[SB-1:0];
									h = (hits_q[s] == '1) ? hits_q[s] : hits_q[s] + 32'd1;
									hits_q[s] <= h;
									lh_id_q <= id_q[s];
									lh_valid_q <= 1'b1;
									r = entry(id_q[s], addr_q[s], kind_q[s],
										cpu_q[s], en_q[s], h);
									r.hit = 1'b1;
								end
							end
							bwt_pkg::F_LIST_ALL, bwt_pkg::F_LIST_CPU: begin
								d = 1'b0;
								prev_q <= '0;
								n_q <= '0;
								state_q <= LIST;
							end
							bwt_pkg::F_LAST_HIT: begin
								if (lh_valid_q && !lh_s[SB]) begin
									s = lh_s[SB-1:0];
									r = entry(id_q[s], addr_q[s], kind_q[s],
										cpu_q[s], en_q[s], hits_q[s]);
								end
							end
							default: d = 1'b0;
						endcase
						rsp <= r;
					end
				end
				LIST: begin
					// one entry per cycle; a lookahead pass is avoided by marking
					// last when nothing larger remains
					if (lst_s[SB]) begin
						if (n_q == '0) begin
							d = 1'b1;
							rsp <= r;
						end
						state_q <= IDLE;
					end else begin
						s = lst_s[SB-1:0];
						r = entry(id_q[s], addr_q[s], kind_q[s], cpu_q[s],
							en_q[s], hits_q[s]);
						r.last = 1'b0;
						d = 1'b1;
						rsp <= r;
						prev_q <= {1'b0, id_q[s]} + 17'd1;
						n_q <= n_q + 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
			done <= d;
		end
	end

	a_list_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pop) else $error("pop while listing");
	a_list_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CB'(N)) else $error("list count");
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> rsp.entry_valid && lh_valid_q) else $error("hit");

endmodule

FILE: rtl/core/bwt_out.sv
// output stage: registers each result and holds list entries back so a list run can mark its final one
module bwt_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          done,
	input  bwt_pkg::rsp_t rsp,
	output logic          strobe,
	output bwt_pkg::rsp_t result
);

	logic          hold_q;
	bwt_pkg::rsp_t held_q;

	// a list result is open until the next result arrives or the run ends
	always_ff @(posedge clk or negedge arst_n) begin
		logic          stb_n;
		logic          hold_n;
		bwt_pkg::rsp_t res_n;
		bwt_pkg::rsp_t held_n;
		if (!arst_n) begin
			hold_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			stb_n = 1'b0;
			hold_n = hold_q;
			res_n = result;
			held_n = held_q;
			if (hold_q) begin
				stb_n = 1'b1;
				res_n = held_q;
				if (!done || rsp.last) res_n.last = 1'b1;
				hold_n = 1'b0;
			end
			if (done) begin
				if (rsp.last && !hold_q) begin
					stb_n = 1'b1;
					res_n = rsp;
				end else begin
					held_n = rsp;
					hold_n = 1'b1;
				end
			end
			strobe <= stb_n;
			hold_q <= hold_n;
			result <= res_n;
			held_q <= held_n;
		end
	end

	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(done) || $past(hold_q)) else $error("strobe");
	a_strobe_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.entry_valid) |-> result.last) else $error("last");
	a_hold_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q && !done) |=> !hold_q) else $error("hold");

endmodule

FILE: rtl/core/breakpoint_watchpoint_table_top.sv
// breakpoint and watchpoint table, 16 entries
// request: start with req; taken at a rising edge where start is high and busy is low
// unused func codes (11..15) are taken and give no result
// result: strobe high for one cycle with result; the receiver cannot stall
// a two-entry request fifo sits in front of the table sequencer; busy is
// fifo full
// single-result requests: one per cycle unless a list run holds the sequencer; each
// passes the fifo, done and output registers before strobe; a list request holds the
// sequencer; its results come one per cycle in id order, last marks the final one
// checks compare all entries in parallel and count the smallest-id match
// reset clears the table, sets next id to 1 and forgets the last hit;
// no clearing pass is needed
module breakpoint_watchpoint_table_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bwt_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output bwt_pkg::rsp_t result
);

	logic          pending, pop, bk_busy, done;
	bwt_pkg::req_t head;
	bwt_pkg::rsp_t rsp;

	bwt_front u_front (.clk, .arst_n, .start, .req, .full(busy), .pending,
		.pop, .head);
	bwt_back u_back (.clk, .arst_n, .pending, .head, .pop, .busy(bk_busy),
		.done, .rsp);
	bwt_out u_out (.clk, .arst_n, .done, .rsp, .strobe, .result);

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !bk_busy) else $error("pop busy");

endmodule
